/* sv/tga_rle_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tga_rle_pkg;

  // Decoder phase within the coded stream.
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_RAW    = 2'd1,
    PH_RUN    = 2'd2
  } phase_t;

  // Register indexes on the configuration port (byte address 4 * index).
  localparam logic [1:0] REG_FOUR_BYTE = 2'd0;
  localparam logic [1:0] REG_WIDTH     = 2'd1;
  localparam logic [1:0] REG_HEIGHT    = 2'd2;

  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int M_DATA_W = 72;

  // Packet header codes.
  localparam logic [7:0] RUN_FLAG_MIN = 8'd128;
  localparam logic [7:0] RUN_BIAS     = 8'd127;

  typedef struct packed {
    logic        four_byte_pixels;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [31:0] pixel_count;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  repeat_count;
    logic [31:0] pixel_index;
    logic        image_done;
    logic        overflow_error;
  } result_t;

endpackage

`default_nettype wire

/* sv/tga_rle_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [tga_rle_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [tga_rle_pkg::DATA_W-1:0]   pwdata,
  output logic      [tga_rle_pkg::DATA_W-1:0]   prdata,
  output logic                                  pready,
  output tga_rle_pkg::cfg_t                     cfg
);

  logic        wr;
  logic [1:0]  reg_sel;
  logic [15:0] mul_a;
  logic [15:0] mul_b;
  logic [31:0] product;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  // The pixel count is kept as a register so that the decoder never
  // sees a multiplier in its path; one multiplier serves both writes.
  assign mul_a   = (reg_sel == tga_rle_pkg::REG_WIDTH)  ? pwdata[15:0] : cfg.image_width;
  assign mul_b   = (reg_sel == tga_rle_pkg::REG_HEIGHT) ? pwdata[15:0] : cfg.image_height;
  assign product = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.four_byte_pixels <= 1'b0;
      cfg.image_width      <= 16'd1;
      cfg.image_height     <= 16'd1;
      cfg.pixel_count      <= 32'd1;
    end else if (wr) begin
      case (reg_sel)
        tga_rle_pkg::REG_FOUR_BYTE: begin
          cfg.four_byte_pixels <= pwdata[0];
        end
        tga_rle_pkg::REG_WIDTH: begin
          cfg.image_width <= pwdata[15:0];
          cfg.pixel_count <= product;
        end
        tga_rle_pkg::REG_HEIGHT: begin
          cfg.image_height <= pwdata[15:0];
          cfg.pixel_count  <= product;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      tga_rle_pkg::REG_FOUR_BYTE: prdata = {31'd0, cfg.four_byte_pixels};
      tga_rle_pkg::REG_WIDTH:     prdata = {16'd0, cfg.image_width};
      tga_rle_pkg::REG_HEIGHT:    prdata = {16'd0, cfg.image_height};
      default:                    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* sv/tga_rle_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  tga_rle_pkg::cfg_t       cfg,
  input  wire logic               s_valid,
  output logic                    s_ready,
  input  wire logic [7:0]         s_byte,
  input  wire logic               s_restart,
  output logic                    m_valid,
  input  wire logic               m_ready,
  output tga_rle_pkg::result_t    res
);

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_restart;

  // Decoder state
  tga_rle_pkg::phase_t phase, phase_next;
  logic [7:0]  rem, rem_next;
  logic [1:0]  bip, bip_next;
  logic [23:0] hold, hold_next;
  logic [31:0] next_pix, next_pix_next;
  logic        halted, halted_next;

  // State as seen after an optional restart
  tga_rle_pkg::phase_t e_phase;
  logic [7:0]  e_rem;
  logic [1:0]  e_bip;
  logic [23:0] e_hold;
  logic [31:0] e_next;
  logic        e_halted;

  logic        take_out;
  logic        proc;
  logic        emit;
  logic [32:0] diff;
  logic [31:0] fit;
  logic        fit_zero;
  logic        fit_one;
  logic        run_over;
  logic        run_exact;
  logic [7:0]  rem_dec;
  logic [1:0]  last_bip;
  tga_rle_pkg::result_t res_next;

  assign take_out = !m_valid || m_ready;
  assign proc     = in_valid && take_out;
  assign s_ready  = !in_valid || take_out;

  assign e_phase  = in_restart ? tga_rle_pkg::PH_HEADER : phase;
  assign e_rem    = in_restart ? 8'd0  : rem;
  assign e_bip    = in_restart ? 2'd0  : bip;
  assign e_hold   = in_restart ? 24'd0 : hold;
  assign e_next   = in_restart ? 32'd0 : next_pix;
  assign e_halted = in_restart ? 1'b0  : halted;

  // Pixels still free in the image; zero once the index has reached the count.
  assign diff      = {1'b0, cfg.pixel_count} - {1'b0, e_next};
  assign fit       = diff[32] ? 32'd0 : diff[31:0];
  assign fit_zero  = (fit == 32'd0);
  assign fit_one   = (fit == 32'd1);
  assign run_over  = (fit[31:8] == 24'd0) && (e_rem > fit[7:0]);
  assign run_exact = (fit == {24'd0, e_rem});
  assign rem_dec   = e_rem - 8'd1;
  assign last_bip  = cfg.four_byte_pixels ? 2'd3 : 2'd2;

  always_comb begin
    phase_next    = phase;
    rem_next      = rem;
    bip_next      = bip;
    hold_next     = hold;
    next_pix_next = next_pix;
    halted_next   = halted;
    emit          = 1'b0;
    res_next      = res;
    if (proc) begin
      phase_next    = e_phase;
      rem_next      = e_rem;
      bip_next      = e_bip;
      hold_next     = e_hold;
      next_pix_next = e_next;
      halted_next   = e_halted;
      if (!e_halted) begin
        case (e_phase)
          tga_rle_pkg::PH_RAW, tga_rle_pkg::PH_RUN: begin
            if (e_bip < last_bip) begin
              case (e_bip)
                2'd0:    hold_next[7:0]   = in_byte;
                2'd1:    hold_next[15:8]  = in_byte;
                2'd2:    hold_next[23:16] = in_byte;
                default: hold_next        = e_hold;
              endcase
              bip_next = e_bip + 2'd1;
            end else begin
              emit                    = 1'b1;
              bip_next                = 2'd0;
              res_next.blue           = e_hold[7:0];
              res_next.green          = e_hold[15:8];
              // A byte in the third slot ends a three-byte pixel as its red.
              res_next.red            = (e_bip == 2'd2) ? in_byte : e_hold[23:16];
              res_next.alpha          = (e_bip == 2'd2 || !cfg.four_byte_pixels) ?
                                        8'd0 : in_byte;
              res_next.pixel_index    = e_next;
              res_next.image_done     = 1'b0;
              res_next.overflow_error = 1'b0;
              if (e_phase == tga_rle_pkg::PH_RAW) begin
                if (fit_zero) begin
                  res_next.repeat_count   = 8'd0;
                  res_next.overflow_error = 1'b1;
                  halted_next             = 1'b1;
                end else begin
                  res_next.repeat_count = 8'd1;
                  next_pix_next         = e_next + 32'd1;
                  rem_next              = rem_dec;
                  if (rem_dec == 8'd0) begin
                    phase_next = tga_rle_pkg::PH_HEADER;
                    if (fit_one) begin
                      res_next.image_done = 1'b1;
                      halted_next         = 1'b1;
                    end
                  end
                end
              end else begin
                if (run_over) begin
                  res_next.repeat_count   = fit[7:0];
                  res_next.overflow_error = 1'b1;
                  halted_next             = 1'b1;
                end else begin
                  res_next.repeat_count = e_rem;
                  next_pix_next         = e_next + {24'd0, e_rem};
                  rem_next              = 8'd0;
                  phase_next            = tga_rle_pkg::PH_HEADER;
                  if (run_exact) begin
                    res_next.image_done = 1'b1;
                    halted_next         = 1'b1;
                  end
                end
              end
            end
          end
          default: begin
            if (in_byte < tga_rle_pkg::RUN_FLAG_MIN) begin
              phase_next = tga_rle_pkg::PH_RAW;
              rem_next   = in_byte + 8'd1;
            end else begin
              phase_next = tga_rle_pkg::PH_RUN;
              rem_next   = in_byte - tga_rle_pkg::RUN_BIAS;
            end
            bip_next = 2'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_ready) begin
      in_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      in_byte    <= s_byte;
      in_restart <= s_restart;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= tga_rle_pkg::PH_HEADER;
      rem      <= 8'd0;
      bip      <= 2'd0;
      hold     <= 24'd0;
      next_pix <= 32'd0;
      halted   <= 1'b0;
    end else begin
      phase    <= phase_next;
      rem      <= rem_next;
      bip      <= bip_next;
      hold     <= hold_next;
      next_pix <= next_pix_next;
      halted   <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (take_out) begin
      m_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

/* sv/tga_rle_pixel_decoder.sv */
// TGA run-length pixel decoder.
// Coded pixel bytes enter on the s_ channel, one byte per request; s_tuser
// set on a byte clears the decoder and makes that byte the first packet
// header. Each finished pixel or run leaves on the m_ channel as one request
// with its color, repeat count and first pixel index; m_tlast marks the
// result that completes the image and m_tuser flags a pixel overflow.
// After either of those the decoder drops further bytes until a restart.
// Pixel size and image dimensions are set on the APB port while idle.
// A byte is first taken into the input register, decoded out of it, and
// the result of its decode loads into the result register. Throughput is
// one byte per cycle while the receiver does not stall, set by the single
// decode step between those two registers.
// When the receiver stalls, the result register holds and one more byte
// may still be taken into the input register; after that s_tready drops.
// Reset clears the decoder, the registers to three-byte 1 x 1 images, and
// empties both pipeline registers.
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_pixel_decoder (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [7:0]                         s_tdata,   // data_byte
  input  wire logic                               s_tuser,   // restart
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // red, green, blue, alpha, repeat_count, pixel_index
  output logic      [tga_rle_pkg::M_DATA_W-1:0]   m_tdata,
  output logic                                    m_tlast,   // image_done
  output logic                                    m_tuser,   // overflow_error
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [tga_rle_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [tga_rle_pkg::DATA_W-1:0]     pwdata,
  output logic      [tga_rle_pkg::DATA_W-1:0]     prdata,
  output logic                                    pready
);

  tga_rle_pkg::cfg_t    cfg;
  tga_rle_pkg::result_t res;

  tga_rle_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tga_rle_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_valid   (s_tvalid),
    .s_ready   (s_tready),
    .s_byte    (s_tdata),
    .s_restart (s_tuser),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .res       (res)
  );

  assign m_tdata = {res.pixel_index, res.repeat_count, res.alpha,
                    res.blue, res.green, res.red};
  assign m_tlast = res.image_done;
  assign m_tuser = res.overflow_error;

endmodule

`default_nettype wire

/* sv/tga_rle_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               m_tvalid,
  input wire logic                               m_tready,
  input wire logic [tga_rle_pkg::M_DATA_W-1:0]   m_tdata,
  input wire logic                               m_tlast,
  input wire logic                               m_tuser
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                             && $stable(m_tuser))
    else $error("stalled result changed");

  // Completion and overflow exclude each other.
  a_done_xor_ovf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tlast && m_tuser))
    else $error("image done and overflow on one result");

  // A normal result covers 1 to 128 pixels.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[39:32] != 8'd0 && m_tdata[39:32] <= 8'd128)
    else $error("repeat count out of range");

  // An overflowing packet always fits fewer than 128 pixels.
  a_ovf_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[39:32] < 8'd128)
    else $error("overflow repeat count too large");

endmodule

bind tga_rle_pixel_decoder tga_rle_checker u_chk (.*);

`default_nettype wire
